// File: src/flt_pkg.sv
// Package for the fraction reduction block: the sequencer state type.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package flt_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EUC_ISSUE,
    S_EUC_WAIT,
    S_QN_ISSUE,
    S_QN_WAIT,
    S_QD_ISSUE,
    S_QD_WAIT,
    S_OUT
  } flt_state_t;

endpackage

`default_nettype wire

// File: src/flt_div.sv
// Iterative restoring divider on unsigned magnitudes, one quotient bit per cycle.
// Shared by the Euclid steps and the final quotients; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module flt_div #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             run;

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             fits;

  // The partial remainder stays below the divisor, so WIDTH+1 bits hold the shift.
  assign shifted = {rem, quo[WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(WIDTH);
        quo <= dividend;
        rem <= '0;
        dvs <= divisor;
      end else if (run) begin
        quo <= {quo[WIDTH-2:0], fits};
        rem <= fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

// File: src/fraction_lowest_terms.sv
// The sequencer runs the Euclid remainder steps (at most about 46 for 32 bits),
// each a pass through one shared divider, then divides both magnitudes by the gcd;
// a zero denominator goes straight from idle to the output state.
// Throughput: one transaction at a time; busy stays high until done has pulsed,
// and the next transaction can be accepted in the cycle right after done.
// Reset (rst, synchronous) returns the sequencer to idle and drops any work.
// The result is valid for the single cycle in which done is high.
`timescale 1ns / 1ps
`default_nettype none

module fraction_lowest_terms
  import flt_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] numer_in,
  input  logic signed [31:0] denom_in,
  output logic               done,
  output logic signed [31:0] numer_out,
  output logic signed [31:0] denom_out,
  output logic               ok
);

  localparam int EXT = (WIDTH > 32) ? WIDTH : 32;

  flt_state_t state, state_next;

  logic [WIDTH-1:0] nmag, dmag, xm, ym, qn;
  logic             nneg, dneg, xs, ys;

  logic [EXT-1:0]   n_ext, d_ext;
  logic [WIDTH-1:0] n_w, d_w, nmag_in, dmag_in;

  logic             div_start, div_done;
  logic [WIDTH-1:0] div_a, div_b, div_q, div_r;

  logic             sn, sd;
  logic [WIDTH-1:0] n_res, d_res;
  logic [EXT-1:0]   n_sx, d_sx;

  // Only the low WIDTH bits of an input count; wider configurations zero-extend.
  assign n_ext   = EXT'($unsigned(numer_in));
  assign d_ext   = EXT'($unsigned(denom_in));
  assign n_w     = n_ext[WIDTH-1:0];
  assign d_w     = d_ext[WIDTH-1:0];
  assign nmag_in = n_w[WIDTH-1] ? (~n_w + 1'b1) : n_w;
  assign dmag_in = d_w[WIDTH-1] ? (~d_w + 1'b1) : d_w;

  flt_div #(
    .WIDTH(WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (dmag_in == '0) ? S_OUT : S_EUC_ISSUE;
        end
      end
      S_EUC_ISSUE: state_next = S_EUC_WAIT;
      S_EUC_WAIT: begin
        if (div_done) begin
          state_next = (div_r == '0) ? S_QN_ISSUE : S_EUC_ISSUE;
        end
      end
      S_QN_ISSUE: state_next = S_QN_WAIT;
      S_QN_WAIT: begin
        if (div_done) begin
          state_next = S_QD_ISSUE;
        end
      end
      S_QD_ISSUE: state_next = S_QD_WAIT;
      S_QD_WAIT: begin
        if (div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_a     = xm;
    div_b     = ym;
    busy      = 1'b1;
    done      = 1'b0;
    case (state)
      S_IDLE:      busy = 1'b0;
      S_EUC_ISSUE: div_start = 1'b1;
      S_QN_ISSUE: begin
        div_start = 1'b1;
        div_a     = nmag;
        div_b     = xm;
      end
      S_QD_ISSUE: begin
        div_start = 1'b1;
        div_a     = dmag;
        div_b     = xm;
      end
      S_OUT:   done = 1'b1;
      default: ;
    endcase
  end

  // Each quotient takes the sign of its input against the sign the gcd ended with.
  assign sn    = (qn != '0) && (nneg != xs);
  assign sd    = (div_q != '0) && (dneg != xs);
  assign n_res = sn ? (~qn + 1'b1) : qn;
  assign d_res = sd ? (~div_q + 1'b1) : div_q;
  assign n_sx  = EXT'($signed(n_res));
  assign d_sx  = EXT'($signed(d_res));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          nmag      <= nmag_in;
          dmag      <= dmag_in;
          nneg      <= n_w[WIDTH-1];
          dneg      <= d_w[WIDTH-1];
          xm        <= nmag_in;
          xs        <= n_w[WIDTH-1];
          ym        <= dmag_in;
          ys        <= d_w[WIDTH-1];
          // A zero denominator passes both fields through untouched.
          numer_out <= numer_in;
          denom_out <= denom_in;
          ok        <= 1'b0;
        end
      end
      S_EUC_WAIT: begin
        if (div_done) begin
          xm <= ym;
          xs <= ys;
          ym <= div_r;
          ys <= (div_r != '0) && xs;
        end
      end
      S_QN_WAIT: begin
        if (div_done) begin
          qn <= div_q;
        end
      end
      S_QD_WAIT: begin
        if (div_done) begin
          numer_out <= n_sx[31:0];
          denom_out <= d_sx[31:0];
          ok        <= 1'b1;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_EUC_WAIT || state == S_QN_WAIT || state == S_QD_WAIT))
    else $error("divider finished outside a wait state");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_denom_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && ok) |-> (denom_out != '0))
    else $error("valid result with zero denominator");
`endif

endmodule

`default_nettype wire
